// File: hdl/teq_pkg.sv
// shared types and constants of the timed event queue
package teq_pkg;

  localparam int TIME_W    = 24;
  localparam int ELAPSED_W = 16;
  localparam int CODE_W    = 3;

  typedef struct packed {
    logic                 mode;
    logic [ELAPSED_W-1:0] elapsed_cycles;
    logic [CODE_W-1:0]    event_code;
    logic [TIME_W-1:0]    delay_cycles;
  } teq_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] fired_event;
    logic              fired;
    logic              dropped;
    logic              last;
  } teq_out_t;

  // one queue slot
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] time_left;
    logic [CODE_W-1:0] code;
  } teq_entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_AGE,
    OP_INSERT
  } teq_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    teq_op_t              op;
    logic [ELAPSED_W-1:0] elapsed;
    logic [TIME_W-1:0]    delay;
    logic [CODE_W-1:0]    code;
  } teq_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRE,
    ST_INSERT
  } teq_state_t;

endpackage

// File: hdl/teq_cell.sv
// one slot of the sorted event chain
module teq_cell
  import teq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  teq_ctrl_t  ctrl,
  input  teq_entry_t left_i,
  input  logic       left_le_i,
  input  teq_entry_t right_i,
  output teq_entry_t entry_o,
  output logic       le_o
);

  teq_entry_t entry_r;
  teq_entry_t entry_nxt;

  assign le_o = entry_r.valid && (entry_r.time_left <= ctrl.delay);

  always_comb begin
    entry_nxt = entry_r;
    unique case (ctrl.op)
      OP_HOLD: begin
        entry_nxt = entry_r;
      end
      OP_SHIFT: begin
        entry_nxt = right_i;
      end
      OP_AGE: begin
        // survivors are all above elapsed, no wrap
        entry_nxt.time_left = entry_r.time_left -
                              {{(TIME_W-ELAPSED_W){1'b0}}, ctrl.elapsed};
      end
      OP_INSERT: begin
        if (le_o) begin
          entry_nxt = entry_r;
        end else if (left_le_i) begin
          entry_nxt.valid     = 1'b1;
          entry_nxt.time_left = ctrl.delay;
          entry_nxt.code      = ctrl.code;
        end else begin
          entry_nxt = left_i;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // only the valid bit is reset, the payload follows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.time_left <= entry_nxt.time_left;
    entry_r.code      <= entry_nxt.code;
  end

  assign entry_o = entry_r;

endmodule

// File: hdl/timed_event_queue.sv
// top level: sorted timer event queue built as a chain of cells
// an item with k expired entries keeps busy high after its transfer through a fire step
// for each expired entry, then the aging step and the insert/status step; its k + 1 results,
// at most QUEUE_DEPTH + 1, leave through an output register in the cycle after the cycle
// that makes them; a next item is accepted only once busy has dropped after the insert step
// the receiver cannot stall: every out_strobe cycle is one transfer
// synchronous active-low reset empties the queue and returns to idle
module timed_event_queue
  import teq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  teq_in_t  in_data,
  output logic     out_strobe,
  output teq_out_t out_data
);

  // sequencer state
  teq_state_t state_r;
  teq_state_t state_nxt;

  // item under work
  teq_in_t in_r;

  // result register
  logic     out_strobe_r;
  logic     out_strobe_nxt;
  teq_out_t out_data_r;
  teq_out_t out_data_nxt;

  // chain taps
  teq_entry_t             cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le_vec;
  logic [QUEUE_DEPTH-1:0] vld_vec;
  teq_ctrl_t              ctrl;
  teq_op_t                op;

  logic head_expired;
  logic full;
  logic accept;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // expired entries always form a prefix since the chain stays sorted
  assign head_expired = cell_q[0].valid &&
    (cell_q[0].time_left <= {{(TIME_W-ELAPSED_W){1'b0}}, in_r.elapsed_cycles});
  assign full = cell_q[QUEUE_DEPTH-1].valid;

  // command broadcast: op, elapsed, delay, code
  assign ctrl = {op, in_r.elapsed_cycles, in_r.delay_cycles, in_r.event_code};

  // cell chain: shift moves toward the head, insert moves toward the tail
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    teq_entry_t left_e;
    teq_entry_t right_e;
    logic       left_le;

    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_le = 1'b1;
    end else begin : g_mid
      assign left_e  = cell_q[i-1];
      assign left_le = le_vec[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_q[i+1];
    end

    teq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_i    (left_e),
      .left_le_i (left_le),
      .right_i   (right_e),
      .entry_o   (cell_q[i]),
      .le_o      (le_vec[i])
    );

    assign vld_vec[i] = cell_q[i].valid;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_FIRE;
        end
      end
      ST_FIRE: begin
        if (!head_expired) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // chain command and result
  always_comb begin
    op             = OP_HOLD;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        op = OP_HOLD;
      end
      ST_FIRE: begin
        if (head_expired) begin
          // report the head and pull the rest forward
          op                       = OP_SHIFT;
          out_strobe_nxt           = 1'b1;
          out_data_nxt.fired_event = cell_q[0].code;
          out_data_nxt.fired       = 1'b1;
        end else begin
          op = OP_AGE;
        end
      end
      ST_INSERT: begin
        // status transfer closes the item
        out_strobe_nxt    = 1'b1;
        out_data_nxt.last = 1'b1;
        if (in_r.mode) begin
          if (full) begin
            out_data_nxt.dropped = 1'b1;
          end else begin
            op = OP_INSERT;
          end
        end
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      in_r <= in_data;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // a result only follows a working cycle
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) != ST_IDLE))
    else $error("result strobe without work in the previous cycle");

  // occupied slots stay packed at the head
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec + 1'b1) & vld_vec) == '0)
    else $error("queue slots not contiguous");

  // an accepted item starts with the fire phase
  a_accept_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_FIRE))
    else $error("accepted item did not enter fire phase");

  // a refused enqueue only happens on a full queue
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_data_r.dropped) |-> (full && out_data_r.last))
    else $error("drop flagged without a full queue");

endmodule
